[rtl/fpqu_pkg.sv]
package fpqu_pkg;

   // word format: signed, two integer bits, the rest fraction
   localparam int WORD_WIDTH = 16;
   localparam int FRAC_BITS  = WORD_WIDTH - 2;
   localparam int PROD_WIDTH = 2 * WORD_WIDTH;
   localparam int NUM_PROD   = 16;
   localparam int NUM_OUT    = 9;
   localparam int NUM_COMP   = 4;

   typedef logic signed [WORD_WIDTH-1:0] word_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;

   // fixed constants at the word format
   localparam word_type ONE          = word_type'(1) <<< FRAC_BITS;
   localparam word_type ONE_HALF     = ONE >>> 1;
   localparam word_type THREE_HALVES = ONE + ONE_HALF;

   typedef enum logic [1:0] {
      OP_MULTIPLY  = 2'd0,
      OP_RENORM    = 2'd1,
      OP_TO_MATRIX = 2'd2
   } op_type;

   // product scaled back to the word format, floor rounding, wrapped
   function automatic word_type qmul(input word_type x, input word_type y);
      prod_type p;
      p = prod_type'(x) * prod_type'(y);
      return p[FRAC_BITS+WORD_WIDTH-1:FRAC_BITS];
   endfunction

   // doubling with wrap
   function automatic word_type qdbl(input word_type x);
      return {x[WORD_WIDTH-2:0], 1'b0};
   endfunction

endpackage

[rtl/fixed_point_quaternion_unit.sv]
// Q2.14 quaternion unit: Hamilton product a*b, one-step renormalization of a
// by 1.5 - |a|^2/2, or conversion of a to a 3x3 rotation matrix. One
// transaction is taken on every clock where start is high; busy is always low.
// Each transaction produces exactly one result, shown for one cycle with
// rsp_valid. Results come out in request order and the receiver cannot stall
// them. Each request passes through four register stages: operand select,
// sixteen shared multipliers, sums, and the renormalization multipliers.
// Throughput is one transaction per cycle. Quaternion results use
// rsp_e0..rsp_e3 and return zero on rsp_e4..rsp_e8; the unused request code
// gives all zeros. All arithmetic wraps, products round toward minus infinity.
module fixed_point_quaternion_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_type,
   input  logic signed [15:0] req_a_r,
   input  logic signed [15:0] req_a_i,
   input  logic signed [15:0] req_a_j,
   input  logic signed [15:0] req_a_k,
   input  logic signed [15:0] req_b_r,
   input  logic signed [15:0] req_b_i,
   input  logic signed [15:0] req_b_j,
   input  logic signed [15:0] req_b_k,
   output logic        rsp_valid,
   output logic signed [15:0] rsp_e0,
   output logic signed [15:0] rsp_e1,
   output logic signed [15:0] rsp_e2,
   output logic signed [15:0] rsp_e3,
   output logic signed [15:0] rsp_e4,
   output logic signed [15:0] rsp_e5,
   output logic signed [15:0] rsp_e6,
   output logic signed [15:0] rsp_e7,
   output logic signed [15:0] rsp_e8
);

   // pipeline never stalls
   assign busy = 1'b0;

   // ---------------------------------------------------------------
   // stage 1: operand select for the shared multiplier array
   // ---------------------------------------------------------------
   logic                  v1_ff;
   logic [1:0]            op1_ff;
   fpqu_pkg::word_type    a1_ff [fpqu_pkg::NUM_COMP];
   fpqu_pkg::word_type    x1_ff [fpqu_pkg::NUM_PROD];
   fpqu_pkg::word_type    y1_ff [fpqu_pkg::NUM_PROD];
   fpqu_pkg::word_type    x1_in [fpqu_pkg::NUM_PROD];
   fpqu_pkg::word_type    y1_in [fpqu_pkg::NUM_PROD];
   fpqu_pkg::word_type    ar, ai, aj, ak, br, bi, bj, bk;

   always_comb begin
      ar = fpqu_pkg::word_type'(req_a_r);
      ai = fpqu_pkg::word_type'(req_a_i);
      aj = fpqu_pkg::word_type'(req_a_j);
      ak = fpqu_pkg::word_type'(req_a_k);
      br = fpqu_pkg::word_type'(req_b_r);
      bi = fpqu_pkg::word_type'(req_b_i);
      bj = fpqu_pkg::word_type'(req_b_j);
      bk = fpqu_pkg::word_type'(req_b_k);
      for (int n = 0; n < fpqu_pkg::NUM_PROD; n++) begin
         x1_in[n] = '0;
         y1_in[n] = '0;
      end
      case (fpqu_pkg::op_type'(req_type))
         fpqu_pkg::OP_MULTIPLY: begin
            // slot layout matches the sum terms of stage 3
            x1_in[0]  = ar; y1_in[0]  = br;
            x1_in[1]  = ai; y1_in[1]  = bi;
            x1_in[2]  = aj; y1_in[2]  = bj;
            x1_in[3]  = ak; y1_in[3]  = bk;
            x1_in[4]  = ar; y1_in[4]  = bi;
            x1_in[5]  = ai; y1_in[5]  = br;
            x1_in[6]  = aj; y1_in[6]  = bk;
            x1_in[7]  = ak; y1_in[7]  = bj;
            x1_in[8]  = ar; y1_in[8]  = bj;
            x1_in[9]  = ai; y1_in[9]  = bk;
            x1_in[10] = aj; y1_in[10] = br;
            x1_in[11] = ak; y1_in[11] = bi;
            x1_in[12] = ar; y1_in[12] = bk;
            x1_in[13] = ai; y1_in[13] = bj;
            x1_in[14] = aj; y1_in[14] = bi;
            x1_in[15] = ak; y1_in[15] = br;
         end
         fpqu_pkg::OP_RENORM: begin
            // squares for the squared length
            x1_in[0] = ar; y1_in[0] = ar;
            x1_in[1] = ai; y1_in[1] = ai;
            x1_in[2] = aj; y1_in[2] = aj;
            x1_in[3] = ak; y1_in[3] = ak;
         end
         fpqu_pkg::OP_TO_MATRIX: begin
            // slot 0 ri, 1 ii, 2 jj, 3 kk, 4 rj, 5 rk, 6 ij, 7 ik, 8 jk
            x1_in[0] = ar; y1_in[0] = ai;
            x1_in[1] = ai; y1_in[1] = ai;
            x1_in[2] = aj; y1_in[2] = aj;
            x1_in[3] = ak; y1_in[3] = ak;
            x1_in[4] = ar; y1_in[4] = aj;
            x1_in[5] = ar; y1_in[5] = ak;
            x1_in[6] = ai; y1_in[6] = aj;
            x1_in[7] = ai; y1_in[7] = ak;
            x1_in[8] = aj; y1_in[8] = ak;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff   <= req_type;
      a1_ff[0] <= ar;
      a1_ff[1] <= ai;
      a1_ff[2] <= aj;
      a1_ff[3] <= ak;
      for (int n = 0; n < fpqu_pkg::NUM_PROD; n++) begin
         x1_ff[n] <= x1_in[n];
         y1_ff[n] <= y1_in[n];
      end
   end

   // ---------------------------------------------------------------
   // stage 2: sixteen scaled products
   // ---------------------------------------------------------------
   logic                  v2_ff;
   logic [1:0]            op2_ff;
   fpqu_pkg::word_type    a2_ff [fpqu_pkg::NUM_COMP];
   fpqu_pkg::word_type    p2_ff [fpqu_pkg::NUM_PROD];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      op2_ff <= op1_ff;
      a2_ff  <= a1_ff;
      for (int n = 0; n < fpqu_pkg::NUM_PROD; n++) begin
         p2_ff[n] <= fpqu_pkg::qmul(x1_ff[n], y1_ff[n]);
      end
   end

   // ---------------------------------------------------------------
   // stage 3: sums, matrix terms and the renormalization factor
   // ---------------------------------------------------------------
   logic                  v3_ff;
   logic [1:0]            op3_ff;
   fpqu_pkg::word_type    a3_ff [fpqu_pkg::NUM_COMP];
   fpqu_pkg::word_type    cor3_ff;
   fpqu_pkg::word_type    cor3_in;
   fpqu_pkg::word_type    e3_ff [fpqu_pkg::NUM_OUT];
   fpqu_pkg::word_type    e3_in [fpqu_pkg::NUM_OUT];
   fpqu_pkg::word_type    len2;

   always_comb begin
      // squared length; times one half is an arithmetic shift
      len2    = p2_ff[0] + p2_ff[1] + p2_ff[2] + p2_ff[3];
      cor3_in = fpqu_pkg::THREE_HALVES - (len2 >>> 1);
      for (int n = 0; n < fpqu_pkg::NUM_OUT; n++) begin
         e3_in[n] = '0;
      end
      case (fpqu_pkg::op_type'(op2_ff))
         fpqu_pkg::OP_MULTIPLY: begin
            e3_in[0] = p2_ff[0] - p2_ff[1] - p2_ff[2] - p2_ff[3];
            e3_in[1] = p2_ff[4] + p2_ff[5] + p2_ff[6] - p2_ff[7];
            e3_in[2] = p2_ff[8] - p2_ff[9] + p2_ff[10] + p2_ff[11];
            e3_in[3] = p2_ff[12] + p2_ff[13] - p2_ff[14] + p2_ff[15];
         end
         fpqu_pkg::OP_TO_MATRIX: begin
            e3_in[0] = fpqu_pkg::ONE - fpqu_pkg::qdbl(p2_ff[2] + p2_ff[3]);
            e3_in[1] = fpqu_pkg::qdbl(p2_ff[6] - p2_ff[5]);
            e3_in[2] = fpqu_pkg::qdbl(p2_ff[7] + p2_ff[4]);
            e3_in[3] = fpqu_pkg::qdbl(p2_ff[6] + p2_ff[5]);
            e3_in[4] = fpqu_pkg::ONE - fpqu_pkg::qdbl(p2_ff[1] + p2_ff[3]);
            e3_in[5] = fpqu_pkg::qdbl(p2_ff[8] - p2_ff[0]);
            e3_in[6] = fpqu_pkg::qdbl(p2_ff[7] - p2_ff[4]);
            e3_in[7] = fpqu_pkg::qdbl(p2_ff[8] + p2_ff[0]);
            e3_in[8] = fpqu_pkg::ONE - fpqu_pkg::qdbl(p2_ff[1] + p2_ff[2]);
         end
         default: begin
            // renormalize finishes in stage 4; unused code stays zero
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      op3_ff  <= op2_ff;
      a3_ff   <= a2_ff;
      cor3_ff <= cor3_in;
      e3_ff   <= e3_in;
   end

   // ---------------------------------------------------------------
   // stage 4: scale a by the factor, output register
   // ---------------------------------------------------------------
   logic                  v4_ff;
   fpqu_pkg::word_type    e4_ff [fpqu_pkg::NUM_OUT];
   fpqu_pkg::word_type    e4_in [fpqu_pkg::NUM_OUT];

   always_comb begin
      e4_in = e3_ff;
      if (fpqu_pkg::op_type'(op3_ff) == fpqu_pkg::OP_RENORM) begin
         for (int n = 0; n < fpqu_pkg::NUM_COMP; n++) begin
            e4_in[n] = fpqu_pkg::qmul(a3_ff[n], cor3_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      e4_ff <= e4_in;
   end

   assign rsp_valid = v4_ff;
   assign rsp_e0    = e4_ff[0];
   assign rsp_e1    = e4_ff[1];
   assign rsp_e2    = e4_ff[2];
   assign rsp_e3    = e4_ff[3];
   assign rsp_e4    = e4_ff[4];
   assign rsp_e5    = e4_ff[5];
   assign rsp_e6    = e4_ff[6];
   assign rsp_e7    = e4_ff[7];
   assign rsp_e8    = e4_ff[8];

endmodule
